FILE: hw/rtl/pcsa_pkg.sv
// pcsa_pkg: shared types and constants for the phantom clock serial access block.
// No dependencies.
`default_nettype none

package pcsa_pkg;

  // Recognizer key, first bit in bit 0 (32-bit key sent twice).
  localparam logic [63:0] MATCH_PATTERN = 64'h5CA3_3AC5_5CA3_3AC5;
  localparam int unsigned PatLen        = 64;

  // Flag positions inside the time registers.
  localparam logic [7:0] H12_BIT  = 8'h80;
  localparam logic [7:0] OSC_BIT  = 8'h20;
  localparam logic [7:0] RST_BIT  = 8'h10;

  // Strip masks applied when a session closes.
  localparam logic [7:0] MASK_7F  = 8'h7f;
  localparam logic [7:0] MASK_3F  = 8'h3f;
  localparam logic [7:0] MASK_1F  = 8'h1f;
  localparam logic [7:0] MASK_07  = 8'h07;

  typedef logic [6:0] match_pos_t;
  typedef logic [5:0] bit_pos_t;

  // Session status from the store to the recognizer.
  typedef struct packed {
    logic open;
    logic done;
  } sess_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pcsa_ifs.sv
// pcsa_in_if / pcsa_out_if: valid/ready channels of the phantom clock block.
// No dependencies.
`default_nettype none

interface pcsa_in_if;
  logic        valid;
  logic        ready;
  logic        addr_bit0;
  logic        addr_bit2;
  logic [7:0]  rom_byte;
  logic [63:0] time_now;

  modport source (output valid, addr_bit0, addr_bit2, rom_byte, time_now, input ready);
  modport sink   (input valid, addr_bit0, addr_bit2, rom_byte, time_now, output ready);
endinterface

interface pcsa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_out;
  logic        session_done;
  logic [63:0] written_regs;
  logic [7:0]  changed_mask;
  logic        osc_stopped;
  logic        hours_12_mode;
  logic        reset_flag;

  modport source (output valid, data_out, session_done, written_regs, changed_mask,
                  osc_stopped, hours_12_mode, reset_flag, input ready);
  modport sink   (input valid, data_out, session_done, written_regs, changed_mask,
                  osc_stopped, hours_12_mode, reset_flag, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pcsa_recog.sv
// pcsa_recog: 64-step key recognizer on address bit 0.
// Depends on pcsa_pkg.
`default_nettype none

module pcsa_recog (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  beat,
  input  wire logic                  a0,
  input  wire logic                  a2,
  input  wire pcsa_pkg::sess_status_t sess,
  output logic                       hit
);

  pcsa_pkg::match_pos_t match_pos, match_pos_next, pos_inc;
  logic                 blocked, blocked_next;
  logic                 want;

  always_comb begin
    match_pos_next = match_pos;
    blocked_next   = blocked;
    hit            = 1'b0;
    want           = pcsa_pkg::MATCH_PATTERN[match_pos[5:0]];
    pos_inc        = match_pos + 7'd1;
    if (sess.open) begin
      if (sess.done) begin
        match_pos_next = '0;
      end
    end else if (a2) begin
      match_pos_next = '0;
      blocked_next   = 1'b0;
    end else if (!blocked) begin
      if (a0 == want) begin
        match_pos_next = pos_inc;
        // full key seen
        hit = (pos_inc >= 7'(pcsa_pkg::PatLen));
        if (hit) begin
          match_pos_next = 7'(pcsa_pkg::PatLen);
        end
      end else begin
        blocked_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_pos <= '0;
      blocked   <= 1'b0;
    end else if (beat) begin
      match_pos <= match_pos_next;
      blocked   <= blocked_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pcsa_session.sv
// pcsa_session: clock register store, bit-serial session and control flags.
// Depends on pcsa_pkg.
`default_nettype none

module pcsa_session (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   beat,
  input  wire logic                   a0,
  input  wire logic                   a2,
  input  wire logic                   hit,
  input  wire logic [63:0]            time_now,
  output pcsa_pkg::sess_status_t      sess,
  output logic                        rd_bit,
  output logic [63:0]                 written_regs,
  output logic [7:0]                  changed_mask,
  output logic                        osc_next,
  output logic                        h12_next,
  output logic                        rstf_next
);

  logic                 open, open_next;
  pcsa_pkg::bit_pos_t   bit_pos, bit_pos_next;
  logic [63:0]          store, store_next, store_wr, stripped, latched;
  logic [7:0]           marks, marks_next, marks_wr;
  logic                 osc_flag, h12_flag, rst_flag;
  logic                 done;

  assign done      = open && (&bit_pos);
  assign sess      = '{open: open, done: done};
  assign rd_bit    = store[bit_pos];

  always_comb begin
    store_wr = store;
    marks_wr = marks;
    if (!a2) begin
      store_wr[bit_pos] = a0;
      marks_wr          = marks | (8'd1 << bit_pos[5:3]);
    end

    stripped        = store_wr;
    stripped[15:8]  = store_wr[15:8]  & pcsa_pkg::MASK_7F;
    stripped[23:16] = store_wr[23:16] & pcsa_pkg::MASK_7F;
    stripped[31:24] = store_wr[31:24] & pcsa_pkg::MASK_3F;
    stripped[39:32] = store_wr[39:32] & pcsa_pkg::MASK_07;
    stripped[47:40] = store_wr[47:40] & pcsa_pkg::MASK_3F;
    stripped[55:48] = store_wr[55:48] & pcsa_pkg::MASK_1F;

    // time word with current flags overlaid
    latched         = time_now;
    latched[31:24]  = (time_now[31:24] & ~pcsa_pkg::H12_BIT)
                      | (h12_flag ? pcsa_pkg::H12_BIT : 8'h00);
    latched[39:32]  = (time_now[39:32] & ~(pcsa_pkg::OSC_BIT | pcsa_pkg::RST_BIT))
                      | (osc_flag ? pcsa_pkg::OSC_BIT : 8'h00)
                      | (rst_flag ? pcsa_pkg::RST_BIT : 8'h00);

    open_next    = open;
    bit_pos_next = bit_pos;
    store_next   = store;
    marks_next   = marks;
    osc_next     = osc_flag;
    h12_next     = h12_flag;
    rstf_next    = rst_flag;

    if (open) begin
      marks_next   = marks_wr;
      bit_pos_next = bit_pos + 6'd1;
      if (done) begin
        store_next = stripped;
        open_next  = 1'b0;
        h12_next   = store_wr[31];
        osc_next   = store_wr[37];
        rstf_next  = store_wr[36];
      end else begin
        store_next = store_wr;
      end
    end else if (hit) begin
      open_next    = 1'b1;
      bit_pos_next = '0;
      marks_next   = '0;
      store_next   = latched;
    end

    written_regs = done ? stripped : 64'd0;
    changed_mask = done ? marks_wr : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open     <= 1'b0;
      bit_pos  <= '0;
      store    <= '0;
      marks    <= '0;
      osc_flag <= 1'b0;
      h12_flag <= 1'b0;
      rst_flag <= 1'b0;
    end else if (beat) begin
      open     <= open_next;
      bit_pos  <= bit_pos_next;
      store    <= store_next;
      marks    <= marks_next;
      osc_flag <= osc_next;
      h12_flag <= h12_next;
      rst_flag <= rstf_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/phantom_clock_serial_access_top.sv
// phantom_clock_serial_access_top: ROM-socket phantom clock interface, top level.
// Depends on pcsa_pkg, pcsa_ifs, pcsa_recog, pcsa_session.
`default_nettype none

// Each beat on in_ch is one ROM read; each produces exactly one beat on out_ch.
// The recognizer and session logic sit between the input port and a single
// output register, so a new beat is taken every cycle as long as out_ch
// drains (ready = output register empty or being taken). out_ch.valid rises
// on the cycle after the input beat.
// Outside a session, reads with addr_bit2 low feed addr_bit0 into a 64-bit key
// recognizer; a wrong bit blocks it until a read with addr_bit2 high restarts it.
// The full key latches time_now (with the 12-hour, oscillator-stop and reset
// flags overlaid) into the register store and opens a 64-beat session: reads
// with addr_bit2 high return the next clock bit on data_out[0], reads with it
// low write addr_bit0 into that bit. The 64th beat returns session_done with
// the stripped registers and the mask of registers written; the flag outputs
// always carry the flag state after the current beat.
module phantom_clock_serial_access_top (
  input  wire logic  clk,
  input  wire logic  rst,
  pcsa_in_if.sink    in_ch,
  pcsa_out_if.source out_ch
);

  logic                   beat;
  logic                   hit;
  logic                   rd_bit;
  pcsa_pkg::sess_status_t sess;
  logic [63:0]            written_regs;
  logic [7:0]             changed_mask;
  logic                   osc_next, h12_next, rstf_next;
  logic [7:0]             data_val;

  // Output register frees up when empty or being drained this cycle.
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign beat        = in_ch.valid && in_ch.ready;

  pcsa_recog u_recog (
    .clk  (clk),
    .rst  (rst),
    .beat (beat),
    .a0   (in_ch.addr_bit0),
    .a2   (in_ch.addr_bit2),
    .sess (sess),
    .hit  (hit)
  );

  pcsa_session u_session (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .a0           (in_ch.addr_bit0),
    .a2           (in_ch.addr_bit2),
    .hit          (hit),
    .time_now     (in_ch.time_now),
    .sess         (sess),
    .rd_bit       (rd_bit),
    .written_regs (written_regs),
    .changed_mask (changed_mask),
    .osc_next     (osc_next),
    .h12_next     (h12_next),
    .rstf_next    (rstf_next)
  );

  // Clock bit replaces D0 only on read-bit accesses inside a session.
  assign data_val = (sess.open && in_ch.addr_bit2) ? {in_ch.rom_byte[7:1], rd_bit}
                                                   : in_ch.rom_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_ch.valid <= in_ch.valid;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (beat) begin
      out_ch.data_out      <= data_val;
      out_ch.session_done  <= sess.done;
      out_ch.written_regs  <= written_regs;
      out_ch.changed_mask  <= changed_mask;
      out_ch.osc_stopped   <= osc_next;
      out_ch.hours_12_mode <= h12_next;
      out_ch.reset_flag    <= rstf_next;
    end
  end

  // Key match never fires while a session is already open.
  a_hit_only_idle: assert property (@(posedge clk) disable iff (rst)
    beat && hit |-> !sess.open)
    else $error("key match during open session");

  // A closed session leaves the store idle on the next cycle.
  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    beat && sess.done |=> !sess.open)
    else $error("session still open after last beat");

  // Register snapshot and mask only show up on the closing beat.
  a_quiet_outside_done: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.session_done |->
      out_ch.written_regs == 64'd0 && out_ch.changed_mask == 8'd0)
    else $error("register snapshot outside session end");

  // Stripped register 4 keeps only its low three bits.
  a_reg4_stripped: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.session_done |-> out_ch.written_regs[39:35] == 5'd0)
    else $error("flag bits left in register 4");

endmodule

`default_nettype wire
